/* src/wsb_pkg.sv */
package wsb_pkg;

   localparam int SPEED_W     = 8;
   localparam int COUNT_W     = 15;
   localparam int SUM_W       = COUNT_W + 1;
   localparam int PROD_W      = SPEED_W + COUNT_W;
   localparam int QUO_W       = SPEED_W;
   localparam int DIV_CNT_W   = $clog2(QUO_W);
   localparam int OPCODE_W    = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   localparam logic DIR_FORWARD  = 1'b0;
   localparam logic DIR_BACKWARD = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK     = 2'd0,
      OP_STRAIGHT = 2'd1,
      OP_UNLOCK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ADJ,
      ST_NORM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [SUM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* src/wsb_div.sv */
module wsb_div
   import wsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    dsh_ff, dsh_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;

   // One compare and subtract per cycle, restoring form, quotient bit by bit from the top.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUO_W - 1);
         rem_in  = div_req.dividend;
         dsh_in  = PROD_W'({div_req.divisor, {(QUO_W - 1){1'b0}}});
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/wheel_speed_balancer_unit.sv */
// Keeps a two-wheel drive running straight. A straight command (tuser 1) locks the wheels
// and answers with its own direction and speed on both wheels from the EMIT state. A tick
// (tuser 0) carries the left and right pulse counts of one calibration period; while locked
// it answers with corrected wheel speeds through MUL, DIV, ADJ, NORM and EMIT, the bias
// formed by the eight-step compare and subtract divider, or through MUL and EMIT when the
// counts are equal. An unlock (tuser 2), a tick while unlocked and the unused code give no
// transaction on the result side and leave the block ready for the next one. The block
// takes no new transaction until the current one has been handed to the result register,
// which holds one finished result while the next transaction is taken.
module wheel_speed_balancer_unit
   import wsb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // direction, speed, left_count, right_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drive_direction, left_drive, right_drive
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   state_type state_ff, state_in;

   logic               locked_ff, locked_in;
   logic               lock_dir_ff, lock_dir_in;
   logic [SPEED_W-1:0] top_ff, top_in;
   logic [SPEED_W-1:0] left_ff, left_in;
   logic [SPEED_W-1:0] right_ff, right_in;
   logic [COUNT_W-1:0] lc_ff, lc_in;
   logic [COUNT_W-1:0] rc_ff, rc_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic               start_ff, start_in;
   logic               res_dir_ff, res_dir_in;
   logic [SPEED_W-1:0] res_left_ff, res_left_in;
   logic [SPEED_W-1:0] res_right_ff, res_right_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_accept;
   op_type             req_op;
   logic               req_dir;
   logic [SPEED_W-1:0] req_speed;
   logic [COUNT_W-1:0] req_lc;
   logic [COUNT_W-1:0] req_rc;
   logic [COUNT_W-1:0] abs_dev;
   logic [SPEED_W-1:0] norm_left;
   logic [SPEED_W-1:0] norm_right;
   logic               out_free;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_dir    = req_tdata[0];
   assign req_speed  = req_tdata[SPEED_W:1];
   assign req_lc     = req_tdata[SPEED_W+COUNT_W:SPEED_W+1];
   assign req_rc     = req_tdata[SPEED_W+2*COUNT_W:SPEED_W+COUNT_W+1];
   assign abs_dev    = (lc_ff >= rc_ff) ? (lc_ff - rc_ff) : (rc_ff - lc_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      norm_left  = left_ff;
      norm_right = right_ff;
      if (left_ff < right_ff) begin
         norm_left  = left_ff + (top_ff - right_ff);
         norm_right = top_ff;
      end else if (right_ff < left_ff) begin
         norm_right = right_ff + (top_ff - left_ff);
         norm_left  = top_ff;
      end
   end

   assign div_req.start    = start_ff;
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = total_ff;

   wsb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_STRAIGHT: state_in = ST_EMIT;
                  OP_TICK:     state_in = locked_ff ? ST_MUL : ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:  state_in = (lc_ff == rc_ff) ? ST_EMIT : ST_DIV;
         ST_DIV:  state_in = div_rsp.done ? ST_ADJ : ST_DIV;
         ST_ADJ:  state_in = ST_NORM;
         ST_NORM: state_in = ST_EMIT;
         ST_EMIT: state_in = out_free ? ST_IDLE : ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      locked_in    = locked_ff;
      lock_dir_in  = lock_dir_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      start_in     = 1'b0;
      res_dir_in   = res_dir_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_STRAIGHT: begin
                     locked_in = 1'b1;
                     if (req_dir != lock_dir_ff || req_speed != top_ff) begin
                        lock_dir_in = req_dir;
                        top_in      = req_speed;
                        left_in     = req_speed;
                        right_in    = req_speed;
                     end
                     res_dir_in   = req_dir;
                     res_left_in  = req_speed;
                     res_right_in = req_speed;
                  end
                  OP_UNLOCK: locked_in = 1'b0;
                  OP_TICK: begin
                     lc_in = req_lc;
                     rc_in = req_rc;
                  end
                  default: locked_in = locked_ff;
               endcase
            end
         end
         ST_MUL: begin
            if (lc_ff == rc_ff) begin
               res_dir_in   = lock_dir_ff;
               res_left_in  = left_ff;
               res_right_in = right_ff;
            end else begin
               prod_in  = PROD_W'(top_ff) * PROD_W'(abs_dev);
               total_in = SUM_W'(lc_ff) + SUM_W'(rc_ff);
               start_in = 1'b1;
            end
         end
         ST_ADJ: begin
            // Going backward the deviation changes sign, so neither wheel is slowed.
            if (lock_dir_ff == DIR_FORWARD) begin
               if (rc_ff > lc_ff) begin
                  right_in = right_ff - div_rsp.quotient;
               end else if (lc_ff > rc_ff) begin
                  left_in = left_ff - div_rsp.quotient;
               end
            end
         end
         ST_NORM: begin
            left_in      = norm_left;
            right_in     = norm_right;
            res_dir_in   = lock_dir_ff;
            res_left_in  = norm_left;
            res_right_in = norm_right;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_right_ff, res_left_ff, res_dir_ff});
            end
         end
         default: start_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         locked_ff    <= 1'b0;
         lock_dir_ff  <= 1'b0;
         top_ff       <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         lock_dir_ff  <= lock_dir_in;
         top_ff       <= top_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lc_ff        <= lc_in;
      rc_ff        <= rc_in;
      prod_ff      <= prod_in;
      total_ff     <= total_in;
      res_dir_ff   <= res_dir_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/wsb_checker.sv */
module wsb_checker
   import wsb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [OPCODE_W-1:0]   req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   // A result that has not been taken stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction changed before it was taken");

   // A straight command keeps the block busy while its result is formed.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == OP_STRAIGHT |=> !req_tready)
      else $error("block took a transaction while a straight command was in work");

   // An unlock produces no work, so the block is ready again at once.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == OP_UNLOCK |=> req_tready && !$rose(rsp_tvalid))
      else $error("unlock left the block busy or produced a result");

   // Nothing is offered on the result side straight out of reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind wheel_speed_balancer_unit wsb_checker u_checker (.*);

/* dv/tb_wheel_speed_balancer_unit.sv */
module tb_wheel_speed_balancer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import wsb_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
   localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASE_ITEMS    = 255;

   typedef struct packed {
      logic               dir;
      logic [SPEED_W-1:0] left;
      logic [SPEED_W-1:0] right;
   } drive_type;

   class drive_balance_board;
      logic               locked;
      logic               held_dir;
      logic [SPEED_W-1:0] top_speed;
      logic [SPEED_W-1:0] left_now;
      logic [SPEED_W-1:0] right_now;
      drive_type          expected_drives[$];
      int unsigned        errors;

      function new();
         locked    = 1'b0;
         held_dir  = DIR_FORWARD;
         top_speed = '0;
         left_now  = '0;
         right_now = '0;
         errors    = 0;
      endfunction

      function void rebalance(logic [COUNT_W-1:0] lc, logic [COUNT_W-1:0] rc);
         int                 dev;
         int unsigned        absdev;
         int unsigned        total;
         logic [SPEED_W-1:0] bias;
         total  = 32'(lc) + 32'(rc);
         dev    = int'(lc) - int'(rc);
         absdev = (dev < 0) ? -dev : dev;
         // Going backward the deviation is mirrored, which in practice disables the bias.
         if (held_dir == DIR_BACKWARD) dev = -dev;
         if (absdev != 0 && total != 0) begin
            bias = 8'((32'(top_speed) * absdev) / total);
            if (dev < 0 && rc >= lc) begin
               right_now = right_now - bias;
            end else if (dev > 0 && lc >= rc) begin
               left_now = left_now - bias;
            end
            if (left_now < right_now) begin
               left_now  = left_now + (top_speed - right_now);
               right_now = top_speed;
            end else if (right_now < left_now) begin
               right_now = right_now + (top_speed - left_now);
               left_now  = top_speed;
            end
         end
      endfunction

      // Returns one when the transaction is one the block acts on.
      function bit take_command(logic [OPCODE_W-1:0] op, logic dir, logic [SPEED_W-1:0] spd,
                                logic [COUNT_W-1:0] lc, logic [COUNT_W-1:0] rc);
         drive_type drive;
         case (op)
            OP_STRAIGHT: begin
               locked = 1'b1;
               if (held_dir != dir || spd != top_speed) begin
                  held_dir  = dir;
                  top_speed = spd;
                  left_now  = spd;
                  right_now = spd;
               end
               drive = '{dir: dir, left: spd, right: spd};
               expected_drives.push_back(drive);
               return 1'b1;
            end
            OP_UNLOCK: begin
               locked = 1'b0;
               return 1'b1;
            end
            OP_TICK: begin
               if (!locked) return 1'b0;
               rebalance(lc, rc);
               drive = '{dir: held_dir, left: left_now, right: right_now};
               expected_drives.push_back(drive);
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void check_drive(logic [RSP_DATA_W-1:0] got);
         drive_type          want;
         logic               got_dir;
         logic [SPEED_W-1:0] got_left;
         logic [SPEED_W-1:0] got_right;
         got_dir   = got[0];
         got_left  = got[SPEED_W:1];
         got_right = got[2*SPEED_W:SPEED_W+1];
         if (expected_drives.size() == 0) begin
            errors++;
            $display("%0t ns: drive with none expected, actual dir %0d left %0d right %0d",
                     $time, got_dir, got_left, got_right);
            return;
         end
         want = expected_drives.pop_front();
         if (want.dir !== got_dir || want.left !== got_left || want.right !== got_right) begin
            errors++;
            $display({"%0t ns: drive expected dir %0d left %0d right %0d,",
                      " actual dir %0d left %0d right %0d"},
                     $time, want.dir, want.left, want.right, got_dir, got_left, got_right);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OPCODE_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   drive_balance_board board;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   int unsigned        quiet_cycles;

   wheel_speed_balancer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_drive(rsp_tdata);
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("wheel_speed_balancer_unit: mismatch");
      $finish;
   end

   task automatic send_command(input logic [OPCODE_W-1:0] op, input logic dir,
                               input logic [SPEED_W-1:0] spd, input logic [COUNT_W-1:0] lc,
                               input logic [COUNT_W-1:0] rc, output bit acted);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rc, lc, spd, dir};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      acted = board.take_command(op, dir, spd, lc, rc);
   endtask

   task automatic wait_for_drives();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.expected_drives.size() != 0);
   endtask

   function automatic logic [SPEED_W-1:0] pick_speed();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return SPEED_W'($urandom_range(255));
      endcase
   endfunction

   function automatic void pick_counts(output logic [COUNT_W-1:0] lc,
                                       output logic [COUNT_W-1:0] rc);
      int base;
      int delta;
      case ($urandom_range(9))
         0: begin
            lc = COUNT_W'($urandom_range(COUNT_MAX));
            rc = COUNT_W'($urandom_range(COUNT_MAX));
         end
         1: begin
            lc = COUNT_W'($urandom_range(COUNT_MAX));
            rc = lc;
         end
         2: begin
            lc = $urandom_range(1) ? COUNT_MAX : '0;
            rc = $urandom_range(1) ? COUNT_MAX : COUNT_W'($urandom_range(COUNT_MAX));
            if ($urandom_range(1)) {lc, rc} = {rc, lc};
         end
         3: begin
            lc = COUNT_W'($urandom_range(40));
            rc = COUNT_W'($urandom_range(40));
         end
         default: begin
            base  = int'($urandom_range(COUNT_MAX));
            delta = int'($urandom_range(300)) - 150;
            lc    = COUNT_W'(base);
            rc    = (base + delta < 0) ? '0 :
                    (base + delta > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(base + delta);
         end
      endcase
   endfunction

   task automatic run_directed();
      bit acted;
      send_command(OP_TICK,     1'b0, 8'd0,   COUNT_MAX, COUNT_MAX, acted);
      send_command(OP_SPARE,    1'b1, 8'd255, COUNT_MAX, 15'd0,     acted);
      send_command(OP_UNLOCK,   1'b0, 8'd0,   15'd0,     15'd0,     acted);
      send_command(OP_STRAIGHT, DIR_FORWARD,  8'd0,   15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd0,     15'd0,     acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd100,   15'd50,    acted);
      send_command(OP_STRAIGHT, DIR_FORWARD,  8'd255, 15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   COUNT_MAX, 15'd0,     acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd0,     COUNT_MAX, acted);
      send_command(OP_STRAIGHT, DIR_FORWARD,  8'd255, 15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd500,   15'd500,   acted);
      send_command(OP_STRAIGHT, DIR_BACKWARD, 8'd200, 15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd1200,  15'd1000,  acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd1000,  15'd1200,  acted);
      send_command(OP_TICK,     1'b0, 8'd0,   COUNT_MAX, COUNT_MAX, acted);
      send_command(OP_SPARE,    1'b0, 8'd17,  15'd3,     15'd9,     acted);
      send_command(OP_UNLOCK,   1'b1, 8'd255, COUNT_MAX, COUNT_MAX, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd10,    15'd20,    acted);
      send_command(OP_STRAIGHT, DIR_BACKWARD, 8'd1,   15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd1,     15'd0,     acted);
      send_command(OP_STRAIGHT, DIR_FORWARD,  8'd1,   15'd0, 15'd0, acted);
      send_command(OP_STRAIGHT, DIR_FORWARD,  8'd128, 15'd0, 15'd0, acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd600,   15'd400,   acted);
      send_command(OP_TICK,     1'b0, 8'd0,   15'd3,     15'd9,     acted);
      send_command(OP_UNLOCK,   1'b0, 8'd0,   15'd0,     15'd0,     acted);
   endtask

   task automatic run_random(input int unsigned target, input bit hold_midway);
      int unsigned        done;
      int unsigned        pick;
      bit                 acted;
      logic               dir;
      logic [SPEED_W-1:0] spd;
      logic [COUNT_W-1:0] lc;
      logic [COUNT_W-1:0] rc;
      done = 0;
      while (done < target) begin
         pick = $urandom_range(99);
         dir  = 1'($urandom_range(1));
         spd  = pick_speed();
         pick_counts(lc, rc);
         if (pick < 12) begin
            // Repeating the held command exercises the path that keeps the wheel speeds.
            if (board.locked && $urandom_range(2) == 0) begin
               dir = board.held_dir;
               spd = board.top_speed;
            end
            send_command(OP_STRAIGHT, dir, spd, lc, rc, acted);
         end else if (pick < 17) begin
            send_command(OP_UNLOCK, dir, spd, lc, rc, acted);
         end else if (pick < 20) begin
            send_command(OP_SPARE, dir, spd, lc, rc, acted);
         end else begin
            send_command(OP_TICK, dir, spd, lc, rc, acted);
         end
         if (acted) done++;
         if (hold_midway && done == target / 2) begin
            wait_for_drives();
            hold_midway = 1'b0;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_TICK;
      rsp_tready    = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      board         = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_ITEMS, 1'b0);
      send_idle_pct = 86;
      run_random(PHASE_ITEMS, 1'b1);
      send_idle_pct = 0;
      stall_pct     = 86;
      run_random(PHASE_ITEMS, 1'b0);
      send_idle_pct = 8;
      stall_pct     = 8;
      run_random(PHASE_ITEMS, 1'b0);

      wait_for_drives();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_drives.size() == 0) begin
         $display("wheel_speed_balancer_unit: match");
      end else begin
         $display("wheel_speed_balancer_unit: mismatch");
      end
      $finish;
   end
endmodule
